// File: src/aldg_pkg.sv
// Package for the arrival list departure gate: payload types, codes and state encoding.
package aldg_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF    = 16;
    localparam int UNIT_ID_W      = 16;
    localparam int OCC_W          = 5;
    localparam int CFG_DATA_W     = 5;

    localparam logic [1:0] FUNC_ARRIVE     = 2'd0;
    localparam logic [1:0] FUNC_DEP_REQ    = 2'd1;
    localparam logic [1:0] FUNC_DID_DEPART = 2'd2;
    localparam logic [1:0] FUNC_CLEAR      = 2'd3;

    localparam logic CFG_MIN_OCC   = 1'b0;
    localparam logic CFG_FIFO_MODE = 1'b1;

    typedef struct packed {
        logic [1:0]           func;
        logic [UNIT_ID_W-1:0] unit_id;
    } req_t;

    typedef struct packed {
        logic             allowed;
        logic [OCC_W-1:0] occupancy;
        logic             overflow;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_SHIFT,
        ST_RESULT
    } state_t;

endpackage

// File: src/arrival_list_departure_gate.sv
// Top level of the arrival list departure gate: ordered ID list in a RAM with search and shift.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid / in_ready    | in_item  (func, unit_id)
//  out     | output    | out_valid / out_ready  | out_item (allowed, occupancy, overflow)
//  cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// The search reads one RAM entry per cycle and stops at a match or at the end of the list.
// A removal adds a shift that moves each entry past the match one place lower, one per
// cycle. A clear skips the search and goes straight to the result.
// Reset empties the list at once; RAM contents past the length are never read.
// A finished result waits in the output register while the next item is accepted.
module arrival_list_departure_gate
#(
    parameter int LIST_DEPTH = aldg_pkg::LIST_DEPTH_DEF,
    parameter int ID_BITS    = aldg_pkg::ID_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  aldg_pkg::req_t              in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output aldg_pkg::rsp_t              out_item,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [aldg_pkg::CFG_DATA_W-1:0] cfg_data
);

    import aldg_pkg::*;

    localparam int IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

    logic [ID_BITS-1:0] mem [LIST_DEPTH];
    logic [ID_BITS-1:0] rdata_reg;

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] min_occ_reg;
    logic                  fifo_mode_reg;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      ra_reg, ra_next;
    logic [IW-1:0]      wa_reg, wa_next;
    logic [IW-1:0]      pos_reg, pos_next;
    logic               pend_reg, pend_next;
    logic               found_reg, found_next;
    logic [1:0]         func_reg, func_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic               allowed_reg, allowed_next;
    logic               overflow_reg, overflow_next;

    logic               out_valid_reg, out_valid_next;
    rsp_t               out_item_reg, out_item_next;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [ID_BITS-1:0] wr_data;

    logic               in_fire;
    logic               match;
    logic               load_out;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign match     = pend_reg && (rdata_reg == id_reg);
    assign load_out  = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // The list RAM: one synchronous read port and one write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_occ_reg   <= '0;
            fifo_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_OCC:   min_occ_reg   <= cfg_data;
                CFG_FIFO_MODE: fifo_mode_reg <= cfg_data[0];
                default:       min_occ_reg   <= min_occ_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (in_item.func == FUNC_CLEAR) ? ST_RESULT : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (match || ra_reg >= count_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_RESULT;
                if (found_reg)
                begin
                    if (func_reg == FUNC_DID_DEPART)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else if (func_reg == FUNC_DEP_REQ && min_occ_reg != '0
                             && CMPW'(count_reg) >= CMPW'(min_occ_reg)
                             && !(fifo_mode_reg && pos_reg != '0))
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (ra_reg >= count_reg)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        ra_next        = ra_reg;
        wa_next        = wa_reg;
        pos_next       = pos_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        func_next      = func_reg;
        id_next        = id_reg;
        allowed_next   = allowed_reg;
        overflow_next  = overflow_reg;
        rd_en          = 1'b0;
        rd_addr        = ra_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = wa_reg;
        wr_data        = rdata_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    func_next     = in_item.func;
                    id_next       = ID_BITS'(in_item.unit_id);
                    allowed_next  = 1'b0;
                    overflow_next = 1'b0;
                    found_next    = 1'b0;
                    ra_next       = '0;
                    if (in_item.func == FUNC_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_SEARCH:
            begin
                // Compare the entry read last cycle; if it does not match, read the next one.
                if (match)
                begin
                    found_next = 1'b1;
                    pos_next   = wa_reg;
                end
                else if (ra_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    wa_next   = ra_reg[IW-1:0];
                    ra_next   = ra_reg + CW'(1);
                end
            end
            ST_DECIDE:
            begin
                ra_next = CW'(pos_reg) + CW'(1);
                case (func_reg)
                    FUNC_ARRIVE:
                    begin
                        if (!found_reg)
                        begin
                            if (count_reg < CW'(LIST_DEPTH))
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IW-1:0];
                                wr_data    = id_reg;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                    end
                    FUNC_DEP_REQ:
                    begin
                        allowed_next = 1'b1;
                        if (min_occ_reg != '0 && found_reg)
                        begin
                            if (CMPW'(count_reg) < CMPW'(min_occ_reg))
                            begin
                                allowed_next = 1'b0;
                            end
                            else if (fifo_mode_reg && pos_reg != '0)
                            begin
                                allowed_next = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        allowed_next = 1'b0;
                    end
                endcase
            end
            ST_SHIFT:
            begin
                // Each entry read one cycle is written one place lower the next.
                wr_en = pend_reg;
                if (ra_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    wa_next   = ra_reg[IW-1:0] - IW'(1);
                    ra_next   = ra_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            ST_RESULT:
            begin
                if (load_out)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.allowed   = allowed_reg;
                    out_item_next.occupancy = OCC_W'(count_reg);
                    out_item_next.overflow  = overflow_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg       <= ra_next;
        wa_reg       <= wa_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        func_reg     <= func_next;
        id_reg       <= id_next;
        allowed_reg  <= allowed_next;
        overflow_reg <= overflow_next;
        out_item_reg <= out_item_next;
    end

endmodule
